### rtl/fts_pkg.sv
// Shared types, codes and constants of the fade transition sequencer.
`default_nettype none

package fts_pkg;

   localparam int unsigned FTS_MAX_MAPS = 256;
   localparam int unsigned TIME_W       = 24;
   localparam int unsigned FRAC_BITS    = 16;
   localparam int unsigned COUNT_W      = 9;
   localparam int unsigned MAP_W        = 8;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 24;
   localparam int unsigned MUL_A_W      = 32;
   localparam int unsigned MUL_B_W      = 18;
   localparam int unsigned PROD_W       = MUL_A_W + MUL_B_W;

   localparam logic [TIME_W-1:0]    FADE_TIME_RESET = 24'd500000;
   localparam logic [COUNT_W-1:0]   MAP_COUNT_RESET = 9'd1;
   localparam logic [FRAC_BITS-1:0] LEVEL_OPAQUE    = 16'hFFFF;
   localparam logic [FRAC_BITS-1:0] LEVEL_CLEAR     = 16'h0000;
   // 3.0 in Q2.16
   localparam logic [MUL_B_W-1:0]   SMOOTH_THREE    = 18'd196608;

   localparam logic [CSR_IDX_W-1:0] CSR_FADE_OUT_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_IN_TIME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_COUNT     = 2'd2;

   typedef enum logic [2:0] {
      MODE_TICK      = 3'd0,
      MODE_FIRST_MAP = 3'd1,
      MODE_MAP_N     = 3'd2,
      MODE_NEXT      = 3'd3,
      MODE_RESULTS   = 3'd4,
      MODE_MENU      = 3'd5,
      MODE_COMMIT    = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_OUT  = 3'd1,
      PH_HOLD = 3'd2,
      PH_PEND = 3'd3,
      PH_IN   = 3'd4,
      PH_REL  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_MENU    = 2'd0,
      KIND_MAP     = 2'd1,
      KIND_RESULTS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_CALC,
      SEQ_WRITE
   } seq_state_type;

   typedef enum logic [1:0] {
      ARITH_IDLE,
      ARITH_DIV,
      ARITH_SQUARE,
      ARITH_CUBE
   } arith_state_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [TIME_W-1:0] delta_time;
      logic [MAP_W-1:0]  map_index;
   } req_type;

   typedef struct packed {
      logic                 accepted;
      logic                 commit_requested;
      logic                 completed;
      logic [FRAC_BITS-1:0] opacity;
      logic [2:0]           phase_now;
      logic [1:0]           active_kind;
      logic [MAP_W-1:0]     active_map;
      logic                 pending_valid;
      logic [1:0]           pending_kind;
      logic [MAP_W-1:0]     pending_map;
      logic                 locked;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] num;
      logic [TIME_W-1:0] den;
   } arith_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS-1:0] smooth;
   } arith_sts_type;

endpackage

`default_nettype wire

### rtl/fts_arith.sv
// Shared divide and multiply unit: smoothstep of num/den in unsigned Q0.16.
`default_nettype none

module fts_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  fts_pkg::arith_cmd_type cmd,
   output fts_pkg::arith_sts_type sts
);
   import fts_pkg::*;

   localparam int unsigned CNT_W = $clog2(FRAC_BITS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS - 1);

   arith_state_type      state_ff, state_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W-1:0]    den_ff, den_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 done_ff, done_in;

   logic [TIME_W:0]      rem_dbl;
   logic [TIME_W:0]      rem_diff;
   logic                 fits;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [PROD_W-1:0]    mul_p;

   // one restoring step: shift the remainder, subtract the divisor if it fits
   assign rem_dbl  = {rem_ff, 1'b0};
   assign rem_diff = rem_dbl - {1'b0, den_ff};
   assign fits     = (rem_dbl >= {1'b0, den_ff});

   // square the quotient, then scale by (3 - 2p)
   assign mul_a = (state_ff == ARITH_CUBE) ? prod_ff[MUL_A_W-1:0]
                                           : MUL_A_W'(quot_ff);
   assign mul_b = (state_ff == ARITH_CUBE) ? (SMOOTH_THREE - {1'b0, quot_ff, 1'b0})
                                           : MUL_B_W'(quot_ff);
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ARITH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         ARITH_IDLE: begin
            if (cmd.start) begin
               rem_in   = cmd.num;
               den_in   = cmd.den;
               quot_in  = '0;
               cnt_in   = '0;
               state_in = ARITH_DIV;
            end
         end
         ARITH_DIV: begin
            rem_in  = fits ? rem_diff[TIME_W-1:0] : rem_dbl[TIME_W-1:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], fits};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ARITH_SQUARE;
            end
         end
         ARITH_SQUARE: begin
            prod_in  = mul_p;
            state_in = ARITH_CUBE;
         end
         ARITH_CUBE: begin
            prod_in  = mul_p;
            done_in  = 1'b1;
            state_in = ARITH_IDLE;
         end
         default: begin
            state_in = ARITH_IDLE;
         end
      endcase
   end

   assign sts.done   = done_ff;
   assign sts.smooth = prod_ff[2*FRAC_BITS +: FRAC_BITS];

endmodule

`default_nettype wire

### rtl/fade_transition_sequencer.sv
// Top level of the fade transition sequencer: phase sequencer, scene state, CSRs.
`default_nettype none

// Fade-out / commit / fade-in sequencer. Each request on req_* is either a
// time tick or a scene request (first map, map n, next map or results,
// results, main menu, complete commit); each produces exactly one response
// on rsp_* carrying the accept/commit/complete flags, the overlay opacity
// (unsigned Q0.16, 65535 is fully opaque), the phase, the active scene and
// the pending destination. Scene requests are taken only in the idle phase
// and only from a suitable scene; a commit is taken only while a commit is
// pending. Timing: the block takes one request at a time, and takes the next
// only after the response of the last one is written. A tick that moves a
// fade without finishing it first goes through the shared arithmetic unit
// (16 restoring divide steps for elapsed/duration, then two passes through
// one 32x18 multiplier for the smoothstep). A response waiting in the output
// register does not block the next request; only a second finished response
// waits for it. Write the CSRs (fade-out time, fade-in time, map count) only
// while the block is idle; a duration of zero acts as one microsecond, and
// the map count is capped at MAX_MAPS.
module fade_transition_sequencer #(
   parameter int unsigned MAX_MAPS = fts_pkg::FTS_MAX_MAPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  fts_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output fts_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [fts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fts_pkg::*;

   // effective map count never exceeds what the 9-bit register can hold
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_MAPS > ((1 << COUNT_W) - 1)) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_MAPS);

   // CSRs
   logic [TIME_W-1:0]    fade_out_time_ff;
   logic [TIME_W-1:0]    fade_in_time_ff;
   logic [COUNT_W-1:0]   map_count_ff;
   logic [COUNT_W-1:0]   eff_count;

   // sequencer
   seq_state_type        seq_ff, seq_in;
   req_type              item_ff;
   logic                 apply;
   logic                 slot_free;
   logic                 arith_start;

   // architectural state
   phase_type            phase_ff, phase_in;
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic [FRAC_BITS-1:0] level_ff, level_in;
   kind_type             scene_kind_ff, scene_kind_in;
   logic [MAP_W-1:0]     scene_map_ff, scene_map_in;
   logic                 dest_valid_ff, dest_valid_in;
   kind_type             dest_kind_ff, dest_kind_in;
   logic [MAP_W-1:0]     dest_map_ff, dest_map_in;

   // tick preparation
   logic [TIME_W-1:0]    e_new_ff;
   logic                 fade_end_ff;
   logic [TIME_W-1:0]    dur_raw;
   logic [TIME_W-1:0]    dur;
   logic [TIME_W:0]      e_sum;
   logic [TIME_W-1:0]    e_clamp;
   logic                 fade_tick;
   logic                 fade_end;

   // result
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 acc, commit_req, done_req;
   logic                 start_ok, start_req;
   kind_type             start_kind;
   logic [MAP_W-1:0]     start_map;
   logic                 pend_now;

   arith_cmd_type        arith_cmd;
   arith_sts_type        arith_sts;

   fts_arith u_fts_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .sts   (arith_sts)
   );

   // ---------------------------------------------------------------- CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_out_time_ff <= FADE_TIME_RESET;
         fade_in_time_ff  <= FADE_TIME_RESET;
         map_count_ff     <= MAP_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FADE_OUT_TIME: fade_out_time_ff <= csr_wdata[TIME_W-1:0];
            CSR_FADE_IN_TIME:  fade_in_time_ff  <= csr_wdata[TIME_W-1:0];
            CSR_MAP_COUNT:     map_count_ff     <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign eff_count = (map_count_ff > COUNT_CAP) ? COUNT_CAP : map_count_ff;

   // ---------------------------------------------------- tick preparation
   // Advance elapsed time by the tick's delta and clamp it at the duration
   // of the current fade; a zero duration counts as one microsecond.
   assign dur_raw   = (phase_ff == PH_OUT) ? fade_out_time_ff : fade_in_time_ff;
   assign dur       = (dur_raw == '0) ? TIME_W'(1) : dur_raw;
   assign e_sum     = {1'b0, elapsed_ff} + {1'b0, item_ff.delta_time};
   assign e_clamp   = (e_sum > {1'b0, dur}) ? dur : e_sum[TIME_W-1:0];
   assign fade_end  = (e_clamp >= dur);
   assign fade_tick = (mode_type'(item_ff.mode) == MODE_TICK) &&
                      ((phase_ff == PH_OUT) || (phase_ff == PH_IN));

   // Latch the clamped time and whether it ends the fade; the shared unit
   // is only needed when the fade keeps going.
   always_ff @(posedge clock) begin
      if (seq_ff == SEQ_EXEC) begin
         e_new_ff    <= e_clamp;
         fade_end_ff <= fade_end;
      end
   end

   assign arith_cmd.start = arith_start;
   assign arith_cmd.num   = e_clamp;
   assign arith_cmd.den   = dur;

   // ------------------------------------------------------------ sequencer
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
      end else begin
         seq_ff <= seq_in;
      end
   end

   always_comb begin
      seq_in      = seq_ff;
      req_ready   = 1'b0;
      arith_start = 1'b0;
      apply       = 1'b0;
      unique case (seq_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               seq_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            if (fade_tick && !fade_end) begin
               arith_start = 1'b1;
               seq_in      = SEQ_CALC;
            end else begin
               seq_in = SEQ_WRITE;
            end
         end
         SEQ_CALC: begin
            if (arith_sts.done) begin
               seq_in = SEQ_WRITE;
            end
         end
         SEQ_WRITE: begin
            // hold until the output register can take the response
            if (slot_free) begin
               apply  = 1'b1;
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // hold the request while it is worked on
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   // ------------------------------------------------ request decode/effect
   // A begin request needs the idle phase and at least one map configured.
   assign start_ok = (phase_ff == PH_IDLE) && (eff_count != '0);

   always_comb begin
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      level_in      = level_ff;
      scene_kind_in = scene_kind_ff;
      scene_map_in  = scene_map_ff;
      dest_valid_in = dest_valid_ff;
      dest_kind_in  = dest_kind_ff;
      dest_map_in   = dest_map_ff;
      acc           = 1'b0;
      commit_req    = 1'b0;
      done_req      = 1'b0;
      start_req     = 1'b0;
      start_kind    = KIND_MENU;
      start_map     = '0;

      unique case (mode_type'(item_ff.mode))
         MODE_TICK: begin
            case (phase_ff)
               PH_OUT: begin
                  elapsed_in = e_new_ff;
                  if (fade_end_ff) begin
                     phase_in   = PH_HOLD;
                     elapsed_in = '0;
                     level_in   = LEVEL_OPAQUE;
                  end else begin
                     level_in = arith_sts.smooth;
                  end
               end
               PH_HOLD: begin
                  phase_in   = PH_PEND;
                  commit_req = 1'b1;
               end
               PH_IN: begin
                  elapsed_in = e_new_ff;
                  if (fade_end_ff) begin
                     phase_in   = PH_REL;
                     elapsed_in = '0;
                     level_in   = LEVEL_CLEAR;
                  end else if (arith_sts.smooth == '0) begin
                     // one minus zero saturates at fully opaque
                     level_in = LEVEL_OPAQUE;
                  end else begin
                     level_in = ~arith_sts.smooth + FRAC_BITS'(1);
                  end
               end
               PH_REL: begin
                  phase_in      = PH_IDLE;
                  dest_valid_in = 1'b0;
                  dest_kind_in  = KIND_MENU;
                  dest_map_in   = '0;
                  done_req      = 1'b1;
               end
               default: ;
            endcase
         end
         MODE_FIRST_MAP: begin
            start_req  = 1'b1;
            start_kind = KIND_MAP;
         end
         MODE_MAP_N: begin
            start_req  = ({1'b0, item_ff.map_index} < eff_count);
            start_kind = KIND_MAP;
            start_map  = item_ff.map_index;
         end
         MODE_NEXT: begin
            if (scene_kind_ff == KIND_MAP) begin
               start_req = 1'b1;
               // advance to the next map, or to results after the last one
               if (({1'b0, scene_map_ff} + COUNT_W'(1)) < eff_count) begin
                  start_kind = KIND_MAP;
                  start_map  = scene_map_ff + MAP_W'(1);
               end else begin
                  start_kind = KIND_RESULTS;
               end
            end
         end
         MODE_RESULTS: begin
            start_req  = (scene_kind_ff == KIND_MAP);
            start_kind = KIND_RESULTS;
         end
         MODE_MENU: begin
            start_req  = (scene_kind_ff != KIND_MENU);
            start_kind = KIND_MENU;
         end
         MODE_COMMIT: begin
            // switch scenes, unless the destination map no longer exists
            if ((phase_ff == PH_PEND) && dest_valid_ff &&
                !((dest_kind_ff == KIND_MAP) && ({1'b0, dest_map_ff} >= eff_count))) begin
               scene_kind_in = dest_kind_ff;
               scene_map_in  = dest_map_ff;
               phase_in      = PH_IN;
               elapsed_in    = '0;
               level_in      = LEVEL_OPAQUE;
               acc           = 1'b1;
            end
         end
         default: ;
      endcase

      // latch the destination and start the fade-out
      if (start_req && start_ok) begin
         acc           = 1'b1;
         dest_valid_in = 1'b1;
         dest_kind_in  = start_kind;
         dest_map_in   = start_map;
         phase_in      = PH_OUT;
         elapsed_in    = '0;
         level_in      = LEVEL_CLEAR;
      end
   end

   assign pend_now = (phase_in == PH_PEND) && dest_valid_in;

   always_comb begin
      rsp_data_in.accepted         = acc;
      rsp_data_in.commit_requested = commit_req;
      rsp_data_in.completed        = done_req;
      rsp_data_in.opacity          = level_in;
      rsp_data_in.phase_now        = phase_in;
      rsp_data_in.active_kind      = scene_kind_in;
      rsp_data_in.active_map       = scene_map_in;
      rsp_data_in.pending_valid    = pend_now;
      rsp_data_in.pending_kind     = pend_now ? dest_kind_in : KIND_MENU;
      rsp_data_in.pending_map      = pend_now ? dest_map_in : '0;
      rsp_data_in.locked           = (phase_in != PH_IDLE);
   end

   // ------------------------------------------------------ state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         elapsed_ff    <= '0;
         level_ff      <= LEVEL_CLEAR;
         scene_kind_ff <= KIND_MENU;
         scene_map_ff  <= '0;
         dest_valid_ff <= 1'b0;
         dest_kind_ff  <= KIND_MENU;
         dest_map_ff   <= '0;
      end else if (apply) begin
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         level_ff      <= level_in;
         scene_kind_ff <= scene_kind_in;
         scene_map_ff  <= scene_map_in;
         dest_valid_ff <= dest_valid_in;
         dest_kind_ff  <= dest_kind_in;
         dest_map_ff   <= dest_map_in;
      end
   end

   // ------------------------------------------------------ output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/fts_checker.sv
// Port-level checker for the fade transition sequencer, bound to the top level.
`default_nettype none

module fts_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fts_pkg::rsp_type rsp_data
);
   import fts_pkg::*;

   // one request at a time: drop ready right after taking a request
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another was in progress");

   // a new response only comes out of a request in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared with no request in progress");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed or dropped");

   // a commit request leaves a destination pending
   a_commit_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.commit_requested) |->
         (rsp_data.pending_valid && rsp_data.locked))
      else $error("commit requested without a pending destination");

endmodule

bind fade_transition_sequencer fts_checker u_fts_checker (.*);

`default_nettype wire

### dv/fade_transition_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fade transition sequencer: directed and random request runs.
module fade_transition_sequencer_tb;
   import fts_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned IDLE_PCT     = 29;
   localparam int unsigned NOISE_PCT    = 12;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned SINK_HOLD    = 400;
   // mode code with no operation behind it
   localparam logic [2:0]  MODE_UNUSED  = 3'd7;

   typedef longint unsigned u64_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   fade_transition_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Sequencer shadow: register copy and phase/scene state, updated once
   // per accepted request.
   // ------------------------------------------------------------------
   logic [TIME_W-1:0]    out_time   = FADE_TIME_RESET;
   logic [TIME_W-1:0]    in_time    = FADE_TIME_RESET;
   logic [COUNT_W-1:0]   map_cnt    = MAP_COUNT_RESET;

   phase_type            seq_phase   = PH_IDLE;
   int unsigned          seq_elapsed = 0;
   logic [FRAC_BITS-1:0] seq_level   = LEVEL_CLEAR;
   kind_type             scene_kind  = KIND_MENU;
   logic [MAP_W-1:0]     scene_map   = '0;
   logic                 dest_valid  = 1'b0;
   kind_type             dest_kind   = KIND_MENU;
   logic [MAP_W-1:0]     dest_map    = '0;

   rsp_type              responses_due[$];
   int unsigned          mismatch_count = 0;
   int unsigned          sent_items     = 0;
   int unsigned          cycle_count    = 0;

   // knobs for the two handshake drivers
   bit                   src_gaps_on       = 1'b1;
   bit                   sink_stalls_on    = 1'b1;
   int unsigned          sink_hold_cycles  = 0;

   // the map count register is 9 bits but only MAX_MAPS maps exist
   function automatic int unsigned usable_maps();
      return (map_cnt > FTS_MAX_MAPS) ? FTS_MAX_MAPS : 32'(map_cnt);
   endfunction

   // smoothstep of e/d in Q0.16: p = e*2^16/d, then p*p*(3 - 2p)
   function automatic int unsigned smooth_level(int unsigned e, int unsigned d);
      u64_type p;
      p = 64'(e);
      p = (p << 16) / 64'(d);
      if (p > 65536) p = 65536;
      return 32'((p * p * (u64_type'(SMOOTH_THREE) - 2 * p)) >> 32);
   endfunction

   function automatic bit open_fade(kind_type k, logic [MAP_W-1:0] m);
      if (usable_maps() == 0 || seq_phase != PH_IDLE) return 1'b0;
      dest_valid  = 1'b1;
      dest_kind   = k;
      dest_map    = m;
      seq_phase   = PH_OUT;
      seq_elapsed = 0;
      seq_level   = LEVEL_CLEAR;
      return 1'b1;
   endfunction

   function automatic bit open_map(int unsigned idx);
      if (idx >= usable_maps()) return 1'b0;
      return open_fade(KIND_MAP, 8'(idx));
   endfunction

   // add the tick to elapsed, clamp at the duration; a zero duration counts as 1 us
   function automatic int unsigned step_elapsed(int unsigned delta, logic [TIME_W-1:0] dur_reg);
      int unsigned dur;
      dur = (dur_reg == 0) ? 1 : 32'(dur_reg);
      seq_elapsed = seq_elapsed + delta;
      if (seq_elapsed > dur) seq_elapsed = dur;
      return dur;
   endfunction

   function automatic rsp_type sequencer_response(req_type r);
      rsp_type     o;
      bit          acc;
      bit          commit;
      bit          done;
      bit          pv;
      int unsigned d;
      int unsigned s;
      int unsigned c;
      acc    = 1'b0;
      commit = 1'b0;
      done   = 1'b0;
      case (r.mode)
         MODE_TICK: begin
            case (seq_phase)
               PH_OUT: begin
                  d = step_elapsed(32'(r.delta_time), out_time);
                  s = smooth_level(seq_elapsed, d);
                  seq_level = (s > 65535) ? LEVEL_OPAQUE : s[15:0];
                  if (seq_elapsed >= d) begin
                     seq_phase   = PH_HOLD;
                     seq_elapsed = 0;
                     seq_level   = LEVEL_OPAQUE;
                  end
               end
               PH_HOLD: begin
                  seq_phase = PH_PEND;
                  commit    = 1'b1;
               end
               PH_IN: begin
                  d = step_elapsed(32'(r.delta_time), in_time);
                  s = 65536 - smooth_level(seq_elapsed, d);
                  seq_level = (s > 65535) ? LEVEL_OPAQUE : s[15:0];
                  if (seq_elapsed >= d) begin
                     seq_phase   = PH_REL;
                     seq_elapsed = 0;
                     seq_level   = LEVEL_CLEAR;
                  end
               end
               PH_REL: begin
                  seq_phase  = PH_IDLE;
                  dest_valid = 1'b0;
                  dest_kind  = KIND_MENU;
                  dest_map   = '0;
                  done       = 1'b1;
               end
               default: ;
            endcase
         end
         MODE_FIRST_MAP: acc = open_map(0);
         MODE_MAP_N:     acc = open_map(32'(r.map_index));
         MODE_NEXT: begin
            if (seq_phase == PH_IDLE && scene_kind == KIND_MAP) begin
               c = usable_maps();
               if (c > 0 && 32'(scene_map) < c - 1) acc = open_map(32'(scene_map) + 1);
               else acc = open_fade(KIND_RESULTS, '0);
            end
         end
         MODE_RESULTS: begin
            if (seq_phase == PH_IDLE && scene_kind == KIND_MAP)
               acc = open_fade(KIND_RESULTS, '0);
         end
         MODE_MENU: begin
            if (seq_phase == PH_IDLE && scene_kind != KIND_MENU)
               acc = open_fade(KIND_MENU, '0);
         end
         MODE_COMMIT: begin
            if (seq_phase == PH_PEND && dest_valid &&
                !(dest_kind == KIND_MAP && 32'(dest_map) >= usable_maps())) begin
               scene_kind  = dest_kind;
               scene_map   = dest_map;
               seq_phase   = PH_IN;
               seq_elapsed = 0;
               seq_level   = LEVEL_OPAQUE;
               acc         = 1'b1;
            end
         end
         default: ;
      endcase
      pv                 = (seq_phase == PH_PEND) && dest_valid;
      o.accepted         = acc;
      o.commit_requested = commit;
      o.completed        = done;
      o.opacity          = seq_level;
      o.phase_now        = seq_phase;
      o.active_kind      = scene_kind;
      o.active_map       = scene_map;
      o.pending_valid    = pv;
      o.pending_kind     = pv ? dest_kind : KIND_MENU;
      o.pending_map      = pv ? dest_map : '0;
      o.locked           = (seq_phase != PH_IDLE);
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Response side: random ready, plus a long hold-off on request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (sink_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         sink_hold_cycles = sink_hold_cycles - 1;
      end else if (sink_stalls_on && $urandom_range(99) < IDLE_PCT) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Compare every response taken against the oldest outstanding one.
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (responses_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
         end else begin
            want = responses_due.pop_front();
            check_field("accepted", want.accepted, rsp_data.accepted);
            check_field("commit_requested", want.commit_requested, rsp_data.commit_requested);
            check_field("completed", want.completed, rsp_data.completed);
            check_field("opacity", want.opacity, rsp_data.opacity);
            check_field("phase_now", want.phase_now, rsp_data.phase_now);
            check_field("active_kind", want.active_kind, rsp_data.active_kind);
            check_field("active_map", want.active_map, rsp_data.active_map);
            check_field("pending_valid", want.pending_valid, rsp_data.pending_valid);
            check_field("pending_kind", want.pending_kind, rsp_data.pending_kind);
            check_field("pending_map", want.pending_map, rsp_data.pending_map);
            check_field("locked", want.locked, rsp_data.locked);
         end
      end
   end

   // Bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("fade_transition_sequencer_tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request side helpers.
   // ------------------------------------------------------------------
   function automatic req_type make_req(logic [2:0] mode, logic [TIME_W-1:0] delta,
                                        logic [MAP_W-1:0] idx);
      req_type r;
      r.mode       = mode;
      r.delta_time = delta;
      r.map_index  = idx;
      return r;
   endfunction

   // Offer one request, hold it until taken, then record its response.
   // Valid stays high afterwards so back-to-back requests need no drop.
   task automatic send_request(req_type r);
      rsp_type want;
      while (src_gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      want = sequencer_response(r);
      responses_due.push_back(want);
      sent_items++;
   endtask

   // Drop valid and hold until every outstanding response is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (responses_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FADE_OUT_TIME: out_time = value;
         CSR_FADE_IN_TIME:  in_time  = value;
         CSR_MAP_COUNT:     map_cnt  = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_duration();
      case ($urandom_range(19))
         0:       return '0;
         1:       return CSR_DATA_W'(1);
         2:       return '1;
         3:       return CSR_DATA_W'($urandom_range(24'hFFFFFF));
         default: return CSR_DATA_W'($urandom_range(5000, 1));
      endcase
   endfunction

   // Pick the next request from the shadow phase: mostly the request that
   // moves the sequence along, with random content, plus some noise.
   function automatic req_type pick_request();
      req_type     r;
      int unsigned dur;
      r = make_req(MODE_TICK, TIME_W'($urandom_range(24'hFFFFFF)),
                   MAP_W'($urandom_range(255)));
      if ($urandom_range(99) < NOISE_PCT) begin
         r.mode = 3'($urandom_range(7));
         return r;
      end
      case (seq_phase)
         PH_IDLE: begin
            case ($urandom_range(4))
               0: r.mode = MODE_FIRST_MAP;
               1: begin
                  r.mode = MODE_MAP_N;
                  if (usable_maps() != 0 && $urandom_range(3) != 0)
                     r.map_index = MAP_W'($urandom_range(usable_maps() - 1));
               end
               2: r.mode = MODE_NEXT;
               3: r.mode = MODE_RESULTS;
               default: r.mode = MODE_MENU;
            endcase
         end
         PH_OUT, PH_IN: begin
            dur = (seq_phase == PH_OUT) ? 32'(out_time) : 32'(in_time);
            if (dur == 0) dur = 1;
            case ($urandom_range(9))
               0: r.delta_time = '0;
               1: ;  // keep the full-range delta
               2: r.delta_time = TIME_W'(dur);
               default: r.delta_time = TIME_W'($urandom_range(dur / 3 + 1, 1));
            endcase
         end
         PH_PEND: begin
            if ($urandom_range(9) != 0) r.mode = MODE_COMMIT;
         end
         default: ;  // a tick moves either hold phase on
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Reset registers: check scene gating, wrong-phase requests and one full
   // transition into map 0.
   task automatic test_scene_gating();
      send_request(make_req(MODE_TICK, '1, '1));            // idle tick: no change
      send_request(make_req(MODE_UNUSED, '1, '1));
      send_request(make_req(MODE_COMMIT, '0, '0));          // nothing pending
      send_request(make_req(MODE_NEXT, '0, '0));            // not on a map
      send_request(make_req(MODE_RESULTS, '0, '0));
      send_request(make_req(MODE_MENU, '0, '0));            // already at menu
      send_request(make_req(MODE_MAP_N, '0, 8'd1));         // beyond map count
      send_request(make_req(MODE_FIRST_MAP, '1, '1));
      send_request(make_req(MODE_FIRST_MAP, '0, '0));       // outside idle
      send_request(make_req(MODE_TICK, 24'd250000, '1));
      send_request(make_req(MODE_COMMIT, '0, '0));          // fading, not pending
      send_request(make_req(MODE_TICK, '1, '0));            // clamp, go opaque
      send_request(make_req(MODE_TICK, '0, '0));            // request the commit
      send_request(make_req(MODE_TICK, '1, '0));            // pending: no change
      send_request(make_req(MODE_COMMIT, '0, '0));
      send_request(make_req(MODE_TICK, 24'd100000, '0));
      send_request(make_req(MODE_TICK, '1, '0));
      send_request(make_req(MODE_TICK, '0, '0));            // release: complete
   endtask

   // Zero durations act as one microsecond; largest map index.
   task automatic test_duration_extremes();
      wait_drained();
      write_csr(CSR_FADE_OUT_TIME, '0);
      write_csr(CSR_FADE_IN_TIME, '0);
      write_csr(CSR_MAP_COUNT, CSR_DATA_W'(FTS_MAX_MAPS));
      send_request(make_req(MODE_MAP_N, '0, '1));
      send_request(make_req(MODE_TICK, '0, '0));
      send_request(make_req(MODE_TICK, 24'd1, '0));
      send_request(make_req(MODE_TICK, '0, '0));
      send_request(make_req(MODE_COMMIT, '0, '0));
      send_request(make_req(MODE_TICK, '1, '0));
      send_request(make_req(MODE_TICK, '0, '0));
   endtask

   // Register writes in the middle of a sequence: shortened fades, a commit
   // to a map past the count, and a zero map count.
   task automatic test_mid_fade_writes();
      wait_drained();
      write_csr(CSR_FADE_OUT_TIME, 24'd1000);
      write_csr(CSR_FADE_IN_TIME, 24'd1000);
      write_csr(CSR_MAP_COUNT, 24'h1FF);                    // capped at MAX_MAPS
      send_request(make_req(MODE_MAP_N, '0, 8'd200));
      send_request(make_req(MODE_TICK, 24'd600, '0));
      wait_drained();
      write_csr(CSR_FADE_OUT_TIME, 24'd300);                // elapsed now past it
      send_request(make_req(MODE_TICK, '0, '0));
      send_request(make_req(MODE_TICK, '0, '0));
      wait_drained();
      write_csr(CSR_MAP_COUNT, 24'd100);                    // destination out of range
      send_request(make_req(MODE_COMMIT, '0, '0));
      wait_drained();
      write_csr(CSR_MAP_COUNT, 24'd201);
      send_request(make_req(MODE_COMMIT, '0, '0));
      send_request(make_req(MODE_TICK, 24'd500, '0));
      wait_drained();
      write_csr(CSR_FADE_IN_TIME, 24'd200);
      send_request(make_req(MODE_TICK, '0, '0));
      send_request(make_req(MODE_TICK, '0, '0));
      wait_drained();
      write_csr(CSR_MAP_COUNT, '0);                         // every begin rejected
      send_request(make_req(MODE_FIRST_MAP, '0, '0));
      send_request(make_req(MODE_MAP_N, '0, '0));
      send_request(make_req(MODE_MENU, '0, '0));
   endtask

   // Hold off the response side while requests keep coming, so the block
   // fills and stalls its input; then pause until everything is back.
   task automatic test_output_backpressure();
      wait_drained();
      write_csr(CSR_FADE_OUT_TIME, 24'd3000);
      write_csr(CSR_FADE_IN_TIME, 24'd3000);
      write_csr(CSR_MAP_COUNT, 24'd8);
      sink_hold_cycles = SINK_HOLD;
      repeat (40) send_request(pick_request());
      wait_drained();
   endtask

   // Long random run of well-formed transitions with noise, fresh register
   // settings between transitions and the odd duration change mid-fade.
   task automatic test_random_transitions();
      int unsigned           start_count;
      int unsigned           done_count;
      logic [CSR_DATA_W-1:0] count_word;
      start_count = sent_items;
      while (sent_items - start_count < RANDOM_ITEMS) begin
         done_count = sent_items - start_count;
         // one stretch with no gaps or stalls at all
         src_gaps_on    = !(done_count >= 300 && done_count < 500);
         sink_stalls_on = src_gaps_on;
         if (seq_phase == PH_IDLE && $urandom_range(99) < 10) begin
            wait_drained();
            case ($urandom_range(19))
               0:       count_word = '0;
               1:       count_word = CSR_DATA_W'(1);
               2:       count_word = CSR_DATA_W'(FTS_MAX_MAPS);
               3:       count_word = {15'($urandom_range(16'h7FFF)),
                                      9'($urandom_range(511, 257))};
               default: count_word = CSR_DATA_W'($urandom_range(FTS_MAX_MAPS, 1));
            endcase
            write_csr(CSR_FADE_OUT_TIME, random_duration());
            write_csr(CSR_FADE_IN_TIME, random_duration());
            write_csr(CSR_MAP_COUNT, count_word);
         end else if ((seq_phase == PH_OUT || seq_phase == PH_IN) &&
                      $urandom_range(99) < 3) begin
            wait_drained();
            write_csr((seq_phase == PH_OUT) ? CSR_FADE_OUT_TIME : CSR_FADE_IN_TIME,
                      random_duration());
         end
         send_request(pick_request());
      end
      src_gaps_on    = 1'b1;
      sink_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_scene_gating();
      test_duration_extremes();
      test_mid_fade_writes();
      test_output_backpressure();
      test_random_transitions();
      wait_drained();
      // let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fade_transition_sequencer_tb: done, clean");
      end else begin
         $display("fade_transition_sequencer_tb: done, errors");
      end
      $finish;
   end

endmodule

### sim.f
rtl/fts_pkg.sv
rtl/fts_arith.sv
rtl/fade_transition_sequencer.sv
rtl/fts_checker.sv
dv/fade_transition_sequencer_tb.sv
